/* src/lpd_pkg.sv */
// shared types and constants for the length prefix deframer
package lpd_pkg;

    // header length in bytes, range 1 to 8
    localparam int unsigned HEADER_BYTES = 4;

    localparam int unsigned CNT_W = 3;
    localparam int unsigned LEN_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STATUS_W = 2;

    // counter value at which the header is complete (counter wraps modulo 8)
    localparam logic [CNT_W-1:0] HDR_CNT_END = CNT_W'(HEADER_BYTES);

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd1048576;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                frame_last;
        logic [STATUS_W-1:0] status;
    } lpd_result_t;

endpackage

/* src/lpd_in_stage.sv */
// input register stage: holds one received byte until the parser takes it
module lpd_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lpd_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                        take,
    output logic                        held_valid,
    output logic [lpd_pkg::BYTE_W-1:0]  held_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [lpd_pkg::BYTE_W-1:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

/* src/lpd_parser.sv */
// frame parser: header assembly, length check, payload count and error lock
module lpd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lpd_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                        proc_en,
    input  logic [lpd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        res_valid,
    output lpd_pkg::lpd_result_t        res
);

    logic [lpd_pkg::LEN_W-1:0] max_len_reg;
    logic [lpd_pkg::CNT_W-1:0] hdr_cnt_reg;
    logic [lpd_pkg::CNT_W-1:0] hdr_cnt_next;
    logic [lpd_pkg::LEN_W-1:0] acc_reg;
    logic [lpd_pkg::LEN_W-1:0] acc_next;
    logic [lpd_pkg::LEN_W-1:0] remain_reg;
    logic [lpd_pkg::LEN_W-1:0] remain_next;
    logic                      locked_reg;
    logic                      locked_next;
    logic [lpd_pkg::LEN_W-1:0] acc_upd;
    logic [lpd_pkg::LEN_W-1:0] remain_dec;

    assign remain_dec = remain_reg - {{(lpd_pkg::LEN_W-1){1'b0}}, 1'b1};

    // place the byte at its header position, a nonzero byte at a later position saturates
    always_comb begin
        acc_upd = acc_reg;
        if (hdr_cnt_reg < 3'd4) begin
            case (hdr_cnt_reg[1:0])
                2'd0:    acc_upd = acc_reg | {24'd0, rx_byte};
                2'd1:    acc_upd = acc_reg | {16'd0, rx_byte, 8'd0};
                2'd2:    acc_upd = acc_reg | {8'd0, rx_byte, 16'd0};
                default: acc_upd = acc_reg | {rx_byte, 24'd0};
            endcase
        end else if (rx_byte != '0) begin
            acc_upd = '1;
        end
    end

    always_comb begin
        hdr_cnt_next = hdr_cnt_reg;
        acc_next     = acc_reg;
        remain_next  = remain_reg;
        locked_next  = locked_reg;
        res_valid    = 1'b0;
        res          = '{payload_byte: rx_byte, frame_last: 1'b0,
                         status: lpd_pkg::ST_PAYLOAD};
        if (proc_en && !locked_reg) begin
            if (remain_reg != '0) begin
                remain_next    = remain_dec;
                res_valid      = 1'b1;
                res.frame_last = (remain_dec == '0);
            end else begin
                hdr_cnt_next = hdr_cnt_reg + {{(lpd_pkg::CNT_W-1){1'b0}}, 1'b1};
                acc_next     = acc_upd;
                if (hdr_cnt_next == lpd_pkg::HDR_CNT_END) begin
                    hdr_cnt_next = '0;
                    acc_next     = '0;
                    if (acc_upd == '0) begin
                        locked_next = 1'b1;
                        res_valid   = 1'b1;
                        res         = '{payload_byte: '0, frame_last: 1'b0,
                                        status: lpd_pkg::ST_ZERO_LEN};
                    end else if (acc_upd > max_len_reg) begin
                        locked_next = 1'b1;
                        res_valid   = 1'b1;
                        res         = '{payload_byte: '0, frame_last: 1'b0,
                                        status: lpd_pkg::ST_TOO_LARGE};
                    end else begin
                        remain_next = acc_upd;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= lpd_pkg::MAX_LEN_RESET;
            hdr_cnt_reg <= '0;
            acc_reg     <= '0;
            remain_reg  <= '0;
            locked_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            hdr_cnt_reg <= hdr_cnt_next;
            acc_reg     <= acc_next;
            remain_reg  <= remain_next;
            locked_reg  <= locked_next;
        end
    end

    // an error result always leaves the parser locked
    a_err_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != lpd_pkg::ST_PAYLOAD) |=> locked_reg)
        else $error("error result without lock");

    // once locked, only reset clears the lock
    a_lock_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        locked_reg |=> locked_reg)
        else $error("lock dropped without reset");

    // no header progress while a payload is still outstanding
    a_hdr_idle_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (remain_reg != '0) |-> (hdr_cnt_reg == '0 && acc_reg == '0))
        else $error("header state busy inside a payload");

    // payload results only come from payload bytes
    a_payload_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == lpd_pkg::ST_PAYLOAD) |-> (remain_reg != '0))
        else $error("payload result outside a payload");

endmodule

/* src/lpd_out_stage.sv */
// result register stage: holds one result beat until the sink takes it
module lpd_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic                            res_valid,
    input  lpd_pkg::lpd_result_t            res,
    output logic                            free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpd_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast,
    output logic [lpd_pkg::STATUS_W-1:0]    m_tuser
);

    logic                 valid_reg;
    logic                 valid_next;
    lpd_pkg::lpd_result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tlast  = res_reg.frame_last;
    assign m_tuser  = res_reg.status;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load && res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

/* src/length_prefix_deframer.sv */
// top level of the cut-through length prefix deframer
// path: an accepted byte passes the input register, the parser logic and the
// result register before its payload or error beat leaves
// throughput: one byte per cycle while the sink is ready; a stalled sink holds the input
// header bytes give no beat; after an error beat all bytes are dropped
// reset: synchronous on aresetn low, clears the valid flags and parser state, max length 1048576
module length_prefix_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_frame_length
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tlast,   // frame_last
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // held byte from the input register
    logic                       held_valid;
    logic [lpd_pkg::BYTE_W-1:0] held_byte;
    // output register can take a beat this cycle
    logic                       out_free;
    // held byte moves through the parser this cycle
    logic                       advance;
    logic                       res_valid;
    lpd_pkg::lpd_result_t       res;

    // a byte moves on only when the result register is empty or draining,
    // so header bytes also wait behind a stalled sink, though they give no beat
    assign advance = held_valid && out_free;

    lpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // parser holds the limit register, header count, length and lock
    lpd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .proc_en     (advance),
        .rx_byte     (held_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    lpd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast),
        .m_tuser   (m_axis_tuser)
    );

endmodule
